/* hdl/lbp_pkg.sv */
// shared constants and types for the 3x3 local binary pattern operator
package lbp_pkg;

    localparam int CFG_W          = 11;
    localparam int PIX_W          = 8;
    localparam int POS_W          = 10;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int MIN_DIM        = 3;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 32;
    localparam int OUT_PAD_W      = OUT_TDATA_W - PIX_W - 2 * POS_W;
    localparam int LINE_W         = 2 * PIX_W;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

endpackage

/* hdl/lbp_line_store.sv */
// line store ram holding the upper and middle rows, one entry per column
module lbp_line_store #(
    parameter int DEPTH = lbp_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [lbp_pkg::LINE_W-1:0] rd_data,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [lbp_pkg::LINE_W-1:0] wr_data
);
    import lbp_pkg::*;

    logic [LINE_W-1:0] mem_reg [DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lbp_3x3_operator_top.sv */
// top level of the streaming 3x3 local binary pattern operator
//
// channel   dir  signals                         payload
// s_axis    in   tvalid tready tdata[7:0]        pixel
// m_axis    out  tvalid tready tdata[31:0] tlast code, centre row, centre col; tlast frame end
// cfg       in   cfg_we cfg_addr cfg_wdata[10:0] image width, image height
//
// one pixel per cycle while the output does not stall; after its last pixel is taken a code passes
// through the line store read, then the compare into the output register
// the single-port-per-direction line store sets the rate: one read and one write a cycle
// reset clears counters, window and valid flags; line store contents stay undefined
// a stalled output holds the compare stage, which in turn holds back s_axis_tready
module lbp_3x3_operator_top #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lbp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] pixel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lbp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [7:0] pattern_code,
                                                              // [17:8] centre_row,
                                                              // [27:18] centre_col
    output logic                              m_axis_tlast,   // frame_last
    input  logic                              cfg_we,
    input  lbp_pkg::reg_index_t               cfg_addr,
    input  logic [lbp_pkg::CFG_W-1:0]         cfg_wdata
);
    import lbp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [LW-1:0]     w_eff;
    logic [CFG_W-1:0]  h_eff;

    logic [CW-1:0]     col_cnt_reg;
    logic [CW-1:0]     col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_next;
    logic [LW-1:0]     col_ext;
    logic [LW-1:0]     col_inc;
    logic [CFG_W-1:0]  row_ext;
    logic [CFG_W-1:0]  row_inc;
    logic [CW-1:0]     col_m1;
    logic [ROW_W-1:0]  row_m1;
    logic              in_emit;
    logic              in_last;
    logic              in_accept;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    pixel_t            s1_pixel_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic [POS_W-1:0]  s1_row_reg;
    logic [POS_W-1:0]  s1_col_reg;
    logic              s1_adv;

    logic [LINE_W-1:0] rd_data;
    pixel_t            top_pix;
    pixel_t            mid_pix;
    pixel_t            win_reg [6];
    pixel_t            ctr;
    pixel_t            code;

    logic              out_valid_reg;
    logic              out_valid_next;
    pixel_t            out_code_reg;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic              out_last_reg;

    // clamped image size
    always_comb
    begin
        priority if (width_reg < CFG_W'(MIN_DIM))
        begin
            w_eff = LW'(MIN_DIM);
        end
        else if (LW'(width_reg) > LW'(MAX_WIDTH))
        begin
            w_eff = LW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = LW'(width_reg);
        end
        priority if (height_reg < CFG_W'(MIN_DIM))
        begin
            h_eff = CFG_W'(MIN_DIM);
        end
        else if (height_reg > CFG_W'(MAX_HEIGHT))
        begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // raster position and border test
    assign col_ext   = LW'(col_cnt_reg);
    assign col_inc   = col_ext + LW'(1);
    assign row_ext   = CFG_W'(row_cnt_reg);
    assign row_inc   = row_ext + CFG_W'(1);
    assign col_m1    = col_cnt_reg - CW'(1);
    assign row_m1    = row_cnt_reg - ROW_W'(1);
    assign in_emit   = (row_ext >= CFG_W'(MIN_DIM - 1)) && (col_ext >= LW'(MIN_DIM - 1))
                       && (row_ext < h_eff) && (col_ext < w_eff);
    assign in_last   = (row_ext == h_eff - CFG_W'(1)) && (col_ext == w_eff - LW'(1));

    assign s1_adv        = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_cnt_next = '0;
                if (row_inc >= h_eff)
                begin
                    row_cnt_next = '0;
                end
                else
                begin
                    row_cnt_next = ROW_W'(row_inc);
                end
            end
            else
            begin
                col_cnt_next = CW'(col_inc);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_emit_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(WIDTH_RESET);
            height_reg <= CFG_W'(HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request captured alongside the line store read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_emit_reg  <= in_emit;
            s1_last_reg  <= in_last;
            s1_pixel_reg <= s_axis_tdata[PIX_W-1:0];
            s1_addr_reg  <= col_cnt_reg;
            s1_row_reg   <= POS_W'(row_m1);
            s1_col_reg   <= POS_W'(col_m1);
        end
    end

    lbp_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (col_cnt_reg),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data ({mid_pix, s1_pixel_reg})
    );

    assign top_pix = rd_data[LINE_W-1:PIX_W];
    assign mid_pix = rd_data[PIX_W-1:0];
    assign ctr     = win_reg[1];

    always_comb
    begin
        code    = '0;
        code[7] = win_reg[4] > ctr;
        code[6] = win_reg[5] > ctr;
        code[5] = win_reg[2] > ctr;
        code[4] = s1_pixel_reg > ctr;
        code[3] = mid_pix > ctr;
        code[2] = top_pix > ctr;
        code[1] = win_reg[0] > ctr;
        code[0] = win_reg[3] > ctr;
    end

    // 3x3 window: entries 0..2 column c-1, entries 3..5 column c-2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top_pix;
            win_reg[1] <= mid_pix;
            win_reg[2] <= s1_pixel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_code_reg <= code;
            out_row_reg  <= s1_row_reg;
            out_col_reg  <= s1_col_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_reg, out_row_reg, out_code_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> $stable(rd_data))
        else $error("line store data changed under a stalled request");

    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && s1_adv && (s1_addr_reg == col_cnt_reg)))
        else $error("line store read and write hit the same column");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_emit_reg) |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten while held");

    a_accept_order: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s1_valid_reg) |-> s1_adv)
        else $error("new request entered while compare stage held");
`endif

endmodule
